### sv/bmi2_deposit_multiply_shift_macros.svh
// Assertion macros used by the checker file of the deposit/multiply/shift unit.
// No dependencies; include by bare file name.
`ifndef BMI2_DEPOSIT_MULTIPLY_SHIFT_MACROS_SVH
`define BMI2_DEPOSIT_MULTIPLY_SHIFT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is low.
`define BDMS_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion sampled on the rising clock edge, live during reset as well.
`define BDMS_ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/bdms_pkg.sv
// Shared types and constants of the deposit/multiply/shift unit.
// No dependencies.
`default_nettype none

package bdms_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned HALF_W      = 32;
    localparam int unsigned IN_TDATA_W  = 200;
    localparam int unsigned OUT_TDATA_W = 128;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned BYTES       = 8;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned OFF_W       = 7;
    localparam int unsigned SHAMT_W     = 6;

    localparam logic [DATA_W-1:0] LOW_MASK = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [1:0] {
        KIND_PDEP = 2'd0,
        KIND_MULX = 2'd1,
        KIND_SHRX = 2'd2
    } t_kind;

    // advance enables of the two inner pipeline stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

`default_nettype wire

### sv/bmi2_deposit_multiply_shift.sv
// Top level of the BMI2 execution unit: bit deposit, wide multiply, logical right shift.
// Depends on bdms_pkg, bdms_mul and bdms_pdep.
//
// Usage:
//   Requests enter on the slave stream (i_s_*): tuser carries the operation kind,
//   tdata the width flag and the three operands. Results leave on the master
//   stream (o_m_*): tdata carries the destination value and the low product half.
//   Every request gives exactly one result, in order; kind 3 gives zeros.
//   Pipeline: a taken request reaches the result register through four
//   register stages (input, partial products / mask counts, carry column /
//   byte offsets, output).
//   Throughput: one request per cycle unless the receiver stalls; stages
//   advance on their own, so a request is taken whenever a stage downstream holds a bubble.
//   Stall: while the receiver holds tready low the result register holds its
//   value, and the stages behind it fill up before o_s_tready falls.
//   Reset (synchronous, active low) empties every stage; no result is shown
//   until a new request has been taken.
`default_nettype none

module bmi2_deposit_multiply_shift (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // wide[0], operand_e[64:1], operand_v[128:65], rdx_value[192:129], zero pad
    input  logic [bdms_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // kind[1:0]
    input  logic [1:0]                            i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // main_result[63:0], low_product[127:64]
    output logic [bdms_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);
    import bdms_pkg::*;

    logic      adv1, adv2, adv3, adv4;
    t_stage_en stage_en;

    logic      r_vld1, r_vld2, r_vld3, r_vld4;
    logic [1:0] r_kind1, r_kind2, r_kind3;
    logic      r_wide1, r_wide2, r_wide3;
    t_word     n_mask, n_e1, n_v1, n_d1;
    t_word     r_e1, r_v1, r_d1;
    logic [SHAMT_W-1:0] shamt;
    t_word     n_shr, r_shr2, r_shr3;
    t_word     mul_hi, mul_lo, dep;
    t_word     n_main, n_low, r_main, r_low;

    // a stage advances when it is empty or the one ahead advances
    assign adv4 = !r_vld4 || i_m_tready;
    assign adv3 = !r_vld3 || adv4;
    assign adv2 = !r_vld2 || adv3;
    assign adv1 = !r_vld1 || adv2;

    assign stage_en.s2 = adv2;
    assign stage_en.s3 = adv3;

    assign o_s_tready = adv1;
    assign o_m_tvalid = r_vld4;
    assign o_m_tdata  = {r_low, r_main};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (adv1) r_vld1 <= i_s_tvalid;
            if (adv2) r_vld2 <= r_vld1;
            if (adv3) r_vld3 <= r_vld2;
            if (adv4) r_vld4 <= r_vld3;
        end
    end

    // cut every operand to 32 bits at narrow width
    assign n_mask = i_s_tdata[0] ? '1 : LOW_MASK;
    assign n_e1   = i_s_tdata[64:1]    & n_mask;
    assign n_v1   = i_s_tdata[128:65]  & n_mask;
    assign n_d1   = i_s_tdata[192:129] & n_mask;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_kind1 <= i_s_tuser;
            r_wide1 <= i_s_tdata[0];
            r_e1    <= n_e1;
            r_v1    <= n_v1;
            r_d1    <= n_d1;
        end
    end

    assign shamt = r_wide1 ? r_v1[SHAMT_W-1:0] : {1'b0, r_v1[SHAMT_W-2:0]};
    assign n_shr = r_e1 >> shamt;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_kind2 <= r_kind1;
            r_wide2 <= r_wide1;
            r_shr2  <= n_shr;
        end
        if (adv3) begin
            r_kind3 <= r_kind2;
            r_wide3 <= r_wide2;
            r_shr3  <= r_shr2;
        end
    end

    bdms_mul u_mul (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (r_d1),
        .i_b   (r_e1),
        .o_hi  (mul_hi),
        .o_lo  (mul_lo)
    );

    bdms_pdep u_pdep (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_mask (r_e1),
        .i_src  (r_v1),
        .o_dep  (dep)
    );

    always_comb begin
        n_main = '0;
        n_low  = '0;
        case (t_kind'(r_kind3))
            KIND_PDEP: begin
                n_main = dep;
            end
            KIND_MULX: begin
                // at narrow width the whole product sits in the low half
                if (r_wide3) begin
                    n_main = mul_hi;
                    n_low  = mul_lo;
                end else begin
                    n_main = DATA_W'(mul_lo[DATA_W-1:HALF_W]);
                    n_low  = DATA_W'(mul_lo[HALF_W-1:0]);
                end
            end
            KIND_SHRX: begin
                n_main = r_shr3;
            end
            default: begin
                n_main = '0;
                n_low  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_main <= n_main;
            r_low  <= n_low;
        end
    end

endmodule

`default_nettype wire

### sv/bdms_mul.sv
// Pipelined 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on bdms_pkg; two register stages, final sum left combinational.
`default_nettype none

module bdms_mul (
    input  logic                i_clk,
    input  bdms_pkg::t_stage_en i_en,
    input  bdms_pkg::t_word     i_a,
    input  bdms_pkg::t_word     i_b,
    output bdms_pkg::t_word     o_hi,
    output bdms_pkg::t_word     o_lo
);
    import bdms_pkg::*;

    logic [HALF_W-1:0] a0, a1, b0, b1;
    t_word             n_p00, n_p01, n_p10, n_p11;
    t_word             r_p00, r_p01, r_p10, r_p11;
    logic [HALF_W+1:0] n_mid, r_mid;
    logic [HALF_W:0]   n_cross, r_cross;
    logic [HALF_W-1:0] r_p00_lo;
    t_word             r_p11_b;

    assign a0 = i_a[HALF_W-1:0];
    assign a1 = i_a[DATA_W-1:HALF_W];
    assign b0 = i_b[HALF_W-1:0];
    assign b1 = i_b[DATA_W-1:HALF_W];

    assign n_p00 = t_word'(a0) * t_word'(b0);
    assign n_p01 = t_word'(a0) * t_word'(b1);
    assign n_p10 = t_word'(a1) * t_word'(b0);
    assign n_p11 = t_word'(a1) * t_word'(b1);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p00 <= n_p00;
            r_p01 <= n_p01;
            r_p10 <= n_p10;
            r_p11 <= n_p11;
        end
    end

    // middle column and the upper halves of the cross products
    assign n_mid = {2'b00, r_p00[DATA_W-1:HALF_W]}
                 + {2'b00, r_p01[HALF_W-1:0]}
                 + {2'b00, r_p10[HALF_W-1:0]};
    assign n_cross = {1'b0, r_p01[DATA_W-1:HALF_W]} + {1'b0, r_p10[DATA_W-1:HALF_W]};

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_mid    <= n_mid;
            r_cross  <= n_cross;
            r_p00_lo <= r_p00[HALF_W-1:0];
            r_p11_b  <= r_p11;
        end
    end

    assign o_hi = r_p11_b + DATA_W'(r_cross) + DATA_W'(r_mid[HALF_W+1:HALF_W]);
    assign o_lo = {r_mid[HALF_W-1:0], r_p00_lo};

endmodule

`default_nettype wire

### sv/bdms_pdep.sv
// Pipelined parallel bit deposit: per-byte mask counts, byte offsets, byte deposit.
// Depends on bdms_pkg; two register stages, the byte deposit left combinational.
`default_nettype none

module bdms_pdep (
    input  logic                i_clk,
    input  bdms_pkg::t_stage_en i_en,
    input  bdms_pkg::t_word     i_mask,
    input  bdms_pkg::t_word     i_src,
    output bdms_pkg::t_word     o_dep
);
    import bdms_pkg::*;

    logic [CNT_W-1:0] n_cnt [BYTES];
    logic [CNT_W-1:0] r_cnt [BYTES];
    t_word            r_mask_a, r_src_a;
    logic [OFF_W-1:0] n_off [BYTES];
    logic [OFF_W-1:0] r_off [BYTES];
    t_word            r_mask_b, r_src_b;

    // count set mask bits in each byte
    always_comb begin
        for (int b = 0; b < BYTES; b++) begin
            n_cnt[b] = '0;
            for (int j = 0; j < BYTE_W; j++) begin
                n_cnt[b] = n_cnt[b] + CNT_W'(i_mask[b*BYTE_W+j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_cnt    <= n_cnt;
            r_mask_a <= i_mask;
            r_src_a  <= i_src;
        end
    end

    // running sum: first source bit used by each byte
    always_comb begin
        n_off[0] = '0;
        for (int b = 1; b < BYTES; b++) begin
            n_off[b] = n_off[b-1] + OFF_W'(r_cnt[b-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_off    <= n_off;
            r_mask_b <= r_mask_a;
            r_src_b  <= r_src_a;
        end
    end

    always_comb begin
        logic [BYTE_W-1:0] chunk;
        logic [CNT_W-1:0]  k;
        o_dep = '0;
        for (int b = 0; b < BYTES; b++) begin
            chunk = BYTE_W'(r_src_b >> r_off[b]);
            k     = '0;
            for (int j = 0; j < BYTE_W; j++) begin
                if (r_mask_b[b*BYTE_W+j]) begin
                    o_dep[b*BYTE_W+j] = chunk[k[CNT_W-2:0]];
                    k                 = k + CNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/bdms_checker.sv
// Port-level checker for the deposit/multiply/shift unit, bound to its top level.
// Depends on bmi2_deposit_multiply_shift_macros.svh and bdms_pkg.
`default_nettype none
`include "bmi2_deposit_multiply_shift_macros.svh"

module bdms_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [bdms_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    // hold a stalled result
    `BDMS_ASSERT_RST(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result changed or dropped")

    // reset empties the output stage
    `BDMS_ASSERT_ALW(a_reset, i_clk, !i_rst_n |=> !o_m_tvalid, "result shown right after reset")

    // an empty output stage means the pipe can take a request
    `BDMS_ASSERT_RST(a_ready, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "request refused with empty output")

    // with the receiver kept ready, a taken request shows up as a valid result
    `BDMS_ASSERT_RST(a_latency, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready |=> o_m_tvalid, "request lost in the pipeline")

endmodule

bind bmi2_deposit_multiply_shift bdms_checker u_bdms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

### bench/bmi2_deposit_multiply_shift_test.sv
// Self-checking bench for bmi2_deposit_multiply_shift: bit deposit, wide multiply, right shift.
// Drives random and directed requests over the stream ports with random idling on both sides.
// Depends on bdms_pkg and the unit under test.

module bmi2_deposit_multiply_shift_test;

    import bdms_pkg::*;

    localparam logic [1:0] KIND_NONE    = 2'd3;
    localparam int unsigned RANDOM_REQS = 1700;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned FIELDS_W    = 3 * DATA_W + 1;

    typedef struct {
        t_word main_result;
        t_word low_product;
    } t_bmi2_result;

    class bmi2_scoreboard;
        t_bmi2_result awaited_results[$];
        int unsigned  errors;

        function new();
            errors = 0;
        endfunction

        // work out the destination value and low product half of one request
        function t_bmi2_result predict_bmi2(logic [1:0] kind, logic wide, t_word e, t_word v,
                                            t_word d);
            t_bmi2_result r;
            logic [2*DATA_W-1:0] prod;
            int unsigned k;
            int unsigned span;
            r.main_result = '0;
            r.low_product = '0;
            k = 0;
            span = wide ? DATA_W : HALF_W;
            if (!wide) begin
                e &= LOW_MASK;
                v &= LOW_MASK;
                d &= LOW_MASK;
            end
            case (kind)
                KIND_PDEP: begin
                    for (int unsigned i = 0; i < span; i++) begin
                        if (e[i]) begin
                            r.main_result[i] = v[k];
                            k++;
                        end
                    end
                end
                KIND_MULX: begin
                    prod = {{DATA_W{1'b0}}, d} * {{DATA_W{1'b0}}, e};
                    if (wide) begin
                        r.main_result = prod[2*DATA_W-1:DATA_W];
                        r.low_product = prod[DATA_W-1:0];
                    end else begin
                        r.main_result = {{HALF_W{1'b0}}, prod[2*HALF_W-1:HALF_W]};
                        r.low_product = {{HALF_W{1'b0}}, prod[HALF_W-1:0]};
                    end
                end
                KIND_SHRX: begin
                    r.main_result = e >> (wide ? v[5:0] : {1'b0, v[4:0]});
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [1:0] kind, logic wide, t_word e, t_word v, t_word d);
            awaited_results.push_back(predict_bmi2(kind, wide, e, v, d));
        endfunction

        function void check_result(t_word main_result, t_word low_product);
            t_bmi2_result exp_r;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: main %h low %h", main_result, low_product);
                return;
            end
            exp_r = awaited_results.pop_front();
            if (main_result !== exp_r.main_result) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("main_result mismatch: expected %h actual %h",
                             exp_r.main_result, main_result);
            end
            if (low_product !== exp_r.low_product) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("low_product mismatch: expected %h actual %h",
                             exp_r.low_product, low_product);
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata    = '0;
    logic [1:0]             s_tuser    = '0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    bmi2_scoreboard board = new();
    int unsigned    cycle_count = 0;
    bit             send_calm = 1'b0;
    bit             take_calm = 1'b0;

    bmi2_deposit_multiply_shift uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // values read just after the edge are those the unit sampled at it
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            board.note_request(s_tuser, s_tdata[0], s_tdata[DATA_W:1],
                               s_tdata[2*DATA_W:DATA_W+1], s_tdata[3*DATA_W:2*DATA_W+1]);
        if (i_rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata[DATA_W-1:0], m_tdata[2*DATA_W-1:DATA_W]);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_word draw_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(0, DATA_W - 1);
            3: return {32'h0, $urandom()};
            4: return {$urandom(), $urandom()} & {$urandom(), $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // called just after an edge; leaves the request presented until it is taken
    task automatic send_request(logic [1:0] kind, logic wide, t_word e, t_word v, t_word d);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_TDATA_W - FIELDS_W){1'b0}}, d, v, e, wide};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // let the last taken request reach the scoreboard before counting
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    initial begin : receiver
        int unsigned stall;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int unsigned r;
        logic [1:0]  kind;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // deposit: full, empty and alternating masks; upper halves dropped at 32 bits
        send_request(KIND_PDEP, 1'b1, '1, '1, '0);
        send_request(KIND_PDEP, 1'b1, '0, '1, '1);
        send_request(KIND_PDEP, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_0F0F, '1);
        send_request(KIND_PDEP, 1'b0, '1, '1, '1);
        send_request(KIND_PDEP, 1'b0, 64'hFFFF_FFFF_8000_0001, 64'hFFFF_FFFF_0000_0002, '0);
        send_request(KIND_PDEP, 1'b1, 64'h8000_0000_0000_0000, 64'h1, '0);
        // multiply: extremes at both widths, upper operand halves ignored at 32 bits
        send_request(KIND_MULX, 1'b1, '1, '0, '1);
        send_request(KIND_MULX, 1'b1, '0, '1, '1);
        send_request(KIND_MULX, 1'b1, 64'h8000_0000_0000_0000, '1, 64'h2);
        send_request(KIND_MULX, 1'b0, '1, '1, '1);
        send_request(KIND_MULX, 1'b0, 64'hDEAD_BEEF_0000_0003, '1, 64'h1234_5678_8000_0000);
        send_request(KIND_MULX, 1'b0, 64'h1, '0, 64'h1);
        // shift: zero, largest and oversized counts at both widths
        send_request(KIND_SHRX, 1'b1, '1, 64'd0, '1);
        send_request(KIND_SHRX, 1'b1, '1, 64'd63, '1);
        send_request(KIND_SHRX, 1'b1, '1, 64'hFFFF_FFFF_FFFF_FFC5, '0);
        send_request(KIND_SHRX, 1'b0, '1, 64'd31, '0);
        send_request(KIND_SHRX, 1'b0, '1, 64'd32, '0);
        send_request(KIND_SHRX, 1'b0, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_FFFF_FFE1, '1);
        // unused kind at both widths
        send_request(KIND_NONE, 1'b1, '1, '1, '1);
        send_request(KIND_NONE, 1'b0, '1, '1, '1);

        // hold off until the pipeline is empty
        drain_results();

        for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2)
                drain_results();
            r = $urandom_range(0, 19);
            kind = (r == 0) ? KIND_NONE : 2'(r % 3);
            send_request(kind, 1'($urandom_range(0, 1)), draw_word(), draw_word(), draw_word());
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/bdms_pkg.sv
sv/bdms_mul.sv
sv/bdms_pdep.sv
sv/bmi2_deposit_multiply_shift.sv
sv/bdms_checker.sv
bench/bmi2_deposit_multiply_shift_test.sv
